FILE: rtl/core/mbrt_pkg.sv
// Shared constants, types and the CRC-16 byte step for the Modbus RTU read master.
package mbrt_pkg;

    // Longest reply frame the block will wait for, in bytes
    localparam int MAX_FRAME = 64;
    localparam int LEN_W     = 7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Input word types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result word kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Finish status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAILED   = 2'd1;
    localparam logic [1:0] ST_DISABLED = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Byte orders
    localparam logic [2:0] ORD_AB   = 3'd0;
    localparam logic [2:0] ORD_BA   = 3'd1;
    localparam logic [2:0] ORD_ABCD = 3'd2;
    localparam logic [2:0] ORD_CDBA = 3'd3;
    localparam logic [2:0] ORD_BADC = 3'd4;
    localparam logic [2:0] ORD_DCBA = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_MAX_ATT  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    // Control from the request stage to the transmit sequencer
    typedef struct packed {
        logic load;   // capture a new request frame
        logic send;   // start shifting the frame out
        logic adv;    // output register takes the current byte
    } tx_ctl_t;

    // One byte of reflected CRC-16, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/mbrt_tx_seq.sv
// Request frame store and byte sequencer; appends the CRC while the frame goes out.
module mbrt_tx_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbrt_pkg::tx_ctl_t    ctl,
    input  logic [7:0]           slave_addr,
    input  logic [7:0]           func_code,
    input  logic [15:0]          reg_addr,
    input  logic [15:0]          reg_count,
    output logic [7:0]           tx_byte,
    output logic                 tx_last,
    output logic                 busy,
    output logic [7:0]           frame_slave
);

    logic [7:0]  frame_reg [6];
    logic        busy_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // Current byte: stored frame, then CRC low and high
    always_comb
    begin
        if (idx_reg == 3'd6)
            tx_byte = crc_reg[7:0];
        else if (idx_reg == 3'd7)
            tx_byte = crc_reg[15:8];
        else
            tx_byte = frame_reg[idx_reg];
    end

    // CRC runs over the six header bytes as they are handed on
    always_comb
    begin
        if (idx_reg < 3'd6)
            crc_next = mbrt_pkg::crc_byte(crc_reg, tx_byte);
        else
            crc_next = crc_reg;
    end

    assign tx_last     = (idx_reg == 3'd7);
    assign busy        = busy_reg;
    assign frame_slave = frame_reg[0];

    // Frame store
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            frame_reg[0] <= slave_addr;
            frame_reg[1] <= func_code;
            frame_reg[2] <= reg_addr[15:8];
            frame_reg[3] <= reg_addr[7:0];
            frame_reg[4] <= reg_count[15:8];
            frame_reg[5] <= reg_count[7:0];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
            crc_reg  <= mbrt_pkg::CRC_INIT;
        end
        else if (ctl.send)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
            crc_reg  <= mbrt_pkg::CRC_INIT;
        end
        else if (ctl.adv)
        begin
            crc_reg <= crc_next;
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg == 3'd7)
                busy_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/modbus_rtu_read_transaction_top.sv
// Top level of the Modbus RTU read master: request stage, reply checker, result register.
//
// Input channel (in_valid/in_ready) carries one word per event: a start, a received
// bus byte, or a millisecond tick. Output channel (out_valid/out_ready) carries the
// result words: request bytes to transmit, or one finish word with status and value.
// Configuration (cfg_valid/cfg_ready, always ready) writes enable, max_attempts and
// response_timeout; write it only while no transaction is in flight.
// An accepted word is processed from the input register once the transmit sequencer is
// idle and the output register is free: a finish word is loaded into the output register,
// and a request frame into the transmit sequencer. Byte and tick words are taken one per
// cycle while the sequencer is idle and the receiver keeps up. A start, or a failed attempt
// that retries, hands eight bytes to the transmit sequencer, which moves one byte per cycle
// into the output register while the receiver keeps up; the next input word waits meanwhile in the input register.
// If the receiver stalls, the output register holds its word and the input
// register fills, then in_ready drops. Reset leaves the block idle with enable 0,
// max_attempts 3 and response_timeout 1000; no clearing pass is needed.
module modbus_rtu_read_transaction_top
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [7:0]         slave_addr,
    input  logic [7:0]         func_code,
    input  logic [15:0]        reg_addr,
    input  logic [15:0]        reg_count,
    input  logic [2:0]         value_order,
    input  logic               signed_value,
    input  logic [7:0]         rx_byte,
    // result words
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic [7:0]         tx_byte,
    output logic               last,
    output logic [1:0]         status,
    output logic signed [31:0] value,
    output logic [7:0]         attempts_used
);

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_WAIT = 1'b1;
    localparam int   LW      = mbrt_pkg::LEN_W;

    // Configuration registers
    logic        enable_reg;
    logic [7:0]  max_att_reg;
    logic [15:0] timeout_reg;

    // Input register
    logic        hold_valid_reg;
    logic [1:0]  h_type_reg;
    logic [7:0]  h_slave_reg;
    logic [7:0]  h_func_reg;
    logic [15:0] h_addr_reg;
    logic [15:0] h_count_reg;
    logic [2:0]  h_order_reg;
    logic        h_sign_reg;
    logic [7:0]  h_rx_reg;

    // Transaction state
    logic          phase_reg,    phase_next;
    logic [7:0]    failed_reg,   failed_next;
    logic [15:0]   ticks_reg,    ticks_next;
    logic [LW-1:0] rx_idx_reg,   rx_idx_next;
    logic [LW-1:0] exp_len_reg,  exp_len_next;
    logic [15:0]   rx_crc_reg,   rx_crc_next;
    logic [7:0]    rep_addr_reg, rep_addr_next;
    logic [7:0]    rep_cnt_reg,  rep_cnt_next;
    logic [31:0]   payload_reg,  payload_next;
    logic [15:0]   tail_reg,     tail_next;
    logic [3:0]    hos_reg,      hos_next;

    // Output register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    logic [1:0]  status_reg;
    logic [31:0] value_reg;
    logic [7:0]  att_reg;

    // Processing results
    logic        res_fin;
    logic        res_send;
    logic        res_load;
    logic [1:0]  fin_status;
    logic [31:0] fin_value;
    logic [7:0]  fin_att;

    logic        out_free;
    logic        proc_fire;
    logic        tx_busy;
    logic        tx_last;
    logic [7:0]  tx_cur;
    logic [7:0]  frame_slave;
    logic [17:0] req_len;
    logic [7:0]  idx8;
    logic [7:0]  exp8;
    logic [7:0]  failed_inc;
    logic [15:0] ticks_inc;
    mbrt_pkg::tx_ctl_t tx_ctl;

    // Decode the captured payload by byte count and held order
    function automatic logic [31:0] decode_value(input logic [7:0]  cnt,
                                                 input logic [31:0] p,
                                                 input logic [3:0]  hos);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [15:0] raw16;
        logic [31:0] raw;
        b0  = p[31:24];
        b1  = p[23:16];
        b2  = p[15:8];
        b3  = p[7:0];
        raw = 32'd0;
        if (cnt == 8'd2)
        begin
            raw16 = (hos[3:1] == mbrt_pkg::ORD_BA) ? {b1, b0} : {b0, b1};
            raw   = (hos[0] && raw16[15]) ? {16'hFFFF, raw16} : {16'h0000, raw16};
        end
        else if (cnt == 8'd4)
        begin
            case (hos[3:1])
                mbrt_pkg::ORD_CDBA: raw = {b2, b3, b0, b1};
                mbrt_pkg::ORD_BADC: raw = {b1, b0, b3, b2};
                mbrt_pkg::ORD_DCBA: raw = {b3, b2, b1, b0};
                default:            raw = {b0, b1, b2, b3};
            endcase
        end
        return raw;
    endfunction

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = hold_valid_reg && !tx_busy && out_free;
    assign in_ready  = !hold_valid_reg || proc_fire;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            max_att_reg <= 8'd3;
            timeout_reg <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mbrt_pkg::CFG_ENABLE:  enable_reg  <= cfg_data[0];
                mbrt_pkg::CFG_MAX_ATT: max_att_reg <= cfg_data[7:0];
                mbrt_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_ready)
            hold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            h_type_reg  <= req_type;
            h_slave_reg <= slave_addr;
            h_func_reg  <= func_code;
            h_addr_reg  <= reg_addr;
            h_count_reg <= reg_count;
            h_order_reg <= value_order;
            h_sign_reg  <= signed_value;
            h_rx_reg    <= rx_byte;
        end
    end

    assign req_len    = 18'd5 + {1'b0, h_count_reg, 1'b0};
    assign idx8       = {{(8-LW){1'b0}}, rx_idx_reg};
    assign exp8       = {{(8-LW){1'b0}}, exp_len_reg};
    assign failed_inc = failed_reg + 8'd1;
    assign ticks_inc  = (ticks_reg != 16'hFFFF) ? ticks_reg + 16'd1 : ticks_reg;

    // Event processing
    always_comb
    begin
        phase_next    = phase_reg;
        failed_next   = failed_reg;
        ticks_next    = ticks_reg;
        rx_idx_next   = rx_idx_reg;
        exp_len_next  = exp_len_reg;
        rx_crc_next   = rx_crc_reg;
        rep_addr_next = rep_addr_reg;
        rep_cnt_next  = rep_cnt_reg;
        payload_next  = payload_reg;
        tail_next     = tail_reg;
        hos_next      = hos_reg;
        res_fin       = 1'b0;
        res_send      = 1'b0;
        res_load      = 1'b0;
        fin_status    = mbrt_pkg::ST_OK;
        fin_value     = 32'd0;
        fin_att       = 8'd0;

        case (h_type_reg)
            mbrt_pkg::REQ_START:
            begin
                phase_next  = PH_IDLE;
                failed_next = 8'd0;
                if (!enable_reg)
                begin
                    res_fin    = 1'b1;
                    fin_status = mbrt_pkg::ST_DISABLED;
                end
                else if (req_len > 18'(mbrt_pkg::MAX_FRAME))
                begin
                    res_fin    = 1'b1;
                    fin_status = mbrt_pkg::ST_TOO_LONG;
                end
                else if (max_att_reg == 8'd0)
                begin
                    res_fin    = 1'b1;
                    fin_status = mbrt_pkg::ST_FAILED;
                end
                else
                begin
                    res_load     = 1'b1;
                    res_send     = 1'b1;
                    exp_len_next = req_len[LW-1:0];
                    hos_next     = {h_order_reg, h_sign_reg};
                end
            end
            mbrt_pkg::REQ_BYTE:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (idx8 == 8'd0)
                        rep_addr_next = h_rx_reg;
                    if (idx8 == 8'd2)
                        rep_cnt_next = h_rx_reg;
                    case (idx8)
                        8'd3:    payload_next[31:24] = payload_reg[31:24] | h_rx_reg;
                        8'd4:    payload_next[23:16] = payload_reg[23:16] | h_rx_reg;
                        8'd5:    payload_next[15:8]  = payload_reg[15:8]  | h_rx_reg;
                        8'd6:    payload_next[7:0]   = payload_reg[7:0]   | h_rx_reg;
                        default: ;
                    endcase
                    if (idx8 + 8'd2 < exp8)
                        rx_crc_next = mbrt_pkg::crc_byte(rx_crc_reg, h_rx_reg);
                    else if (idx8 + 8'd2 == exp8)
                        tail_next = {8'h00, h_rx_reg};
                    else if (idx8 + 8'd1 == exp8)
                        tail_next = tail_reg | {h_rx_reg, 8'h00};
                    rx_idx_next = rx_idx_reg + LW'(1);
                    if (rx_idx_next >= exp_len_reg)
                    begin
                        if (rep_addr_next == frame_slave && tail_next == rx_crc_next)
                        begin
                            res_fin    = 1'b1;
                            fin_status = mbrt_pkg::ST_OK;
                            fin_value  = decode_value(rep_cnt_next, payload_next, hos_reg);
                            fin_att    = failed_reg;
                        end
                        else
                        begin
                            failed_next = failed_inc;
                            if (failed_inc < max_att_reg)
                                res_send = 1'b1;
                            else
                            begin
                                res_fin    = 1'b1;
                                fin_status = mbrt_pkg::ST_FAILED;
                                fin_att    = failed_inc;
                            end
                        end
                    end
                end
            end
            mbrt_pkg::REQ_TICK:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_reg)
                    begin
                        failed_next = failed_inc;
                        if (failed_inc < max_att_reg)
                            res_send = 1'b1;
                        else
                        begin
                            res_fin    = 1'b1;
                            fin_status = mbrt_pkg::ST_FAILED;
                            fin_att    = failed_inc;
                        end
                    end
                end
            end
            default: ;
        endcase

        // A new attempt starts from a clean reply state
        if (res_send)
        begin
            ticks_next    = 16'd0;
            rx_idx_next   = '0;
            rx_crc_next   = mbrt_pkg::CRC_INIT;
            rep_addr_next = 8'd0;
            rep_cnt_next  = 8'd0;
            payload_next  = 32'd0;
            tail_next     = 16'd0;
            phase_next    = PH_WAIT;
        end
        if (res_fin)
            phase_next = PH_IDLE;
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            failed_reg   <= 8'd0;
            ticks_reg    <= 16'd0;
            rx_idx_reg   <= '0;
            exp_len_reg  <= '0;
            rx_crc_reg   <= mbrt_pkg::CRC_INIT;
            rep_addr_reg <= 8'd0;
            rep_cnt_reg  <= 8'd0;
            payload_reg  <= 32'd0;
            tail_reg     <= 16'd0;
            hos_reg      <= 4'd0;
        end
        else if (proc_fire)
        begin
            phase_reg    <= phase_next;
            failed_reg   <= failed_next;
            ticks_reg    <= ticks_next;
            rx_idx_reg   <= rx_idx_next;
            exp_len_reg  <= exp_len_next;
            rx_crc_reg   <= rx_crc_next;
            rep_addr_reg <= rep_addr_next;
            rep_cnt_reg  <= rep_cnt_next;
            payload_reg  <= payload_next;
            tail_reg     <= tail_next;
            hos_reg      <= hos_next;
        end
    end

    // Transmit sequencer
    assign tx_ctl.load = proc_fire && res_load;
    assign tx_ctl.send = proc_fire && res_send;
    assign tx_ctl.adv  = tx_busy && out_free;

    mbrt_tx_seq u_tx_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (tx_ctl),
        .slave_addr  (h_slave_reg),
        .func_code   (h_func_reg),
        .reg_addr    (h_addr_reg),
        .reg_count   (h_count_reg),
        .tx_byte     (tx_cur),
        .tx_last     (tx_last),
        .busy        (tx_busy),
        .frame_slave (frame_slave)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((proc_fire && res_fin) || tx_ctl.adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && res_fin)
        begin
            out_kind_reg <= mbrt_pkg::KIND_DONE;
            tx_byte_reg  <= 8'd0;
            last_reg     <= 1'b1;
            status_reg   <= fin_status;
            value_reg    <= fin_value;
            att_reg      <= fin_att;
        end
        else if (tx_ctl.adv)
        begin
            out_kind_reg <= mbrt_pkg::KIND_TX;
            tx_byte_reg  <= tx_cur;
            last_reg     <= tx_last;
            status_reg   <= mbrt_pkg::ST_OK;
            value_reg    <= 32'd0;
            att_reg      <= 8'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_kind      = out_kind_reg;
    assign tx_byte       = tx_byte_reg;
    assign last          = last_reg;
    assign status        = status_reg;
    assign value         = value_reg;
    assign attempts_used = att_reg;

    // Checks
    a_send_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && res_send) |=> tx_busy)
        else $error("request send did not start the transmit sequencer");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == mbrt_pkg::KIND_DONE) |-> last)
        else $error("finish word not marked last");

    a_fail_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != mbrt_pkg::ST_OK) |-> (value == 32'sd0))
        else $error("non-ok finish carries a value");

    a_tx_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == mbrt_pkg::KIND_TX) |->
            (status == mbrt_pkg::ST_OK && attempts_used == 8'd0 && value == 32'sd0))
        else $error("transmit word carries finish fields");

endmodule

FILE: tb/modbus_rtu_read_transaction_top_tb.sv
// Self-checking testbench for the Modbus RTU read master, with its own model of the master.
`timescale 1ns / 100ps

module modbus_rtu_read_transaction_top_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 24;

    // One input word, all fields
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] count;
        logic [2:0]  order;
        logic        sgn;
        logic [7:0]  rxb;
    } in_word_t;

    // One result word as the master should produce it
    typedef struct {
        logic        kind;
        logic [7:0]  tx;
        logic        last;
        logic [1:0]  st;
        logic [31:0] val;
        logic [7:0]  att;
    } result_word_t;

    typedef enum int {REPLY_GOOD, REPLY_BAD_SLAVE, REPLY_BAD_CRC} reply_fault_t;

    // DUT connections
    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = mbrt_pkg::CFG_ENABLE;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = mbrt_pkg::REQ_TICK;
    logic [7:0]         slave_addr = '0;
    logic [7:0]         func_code = '0;
    logic [15:0]        reg_addr = '0;
    logic [15:0]        reg_count = '0;
    logic [2:0]         value_order = mbrt_pkg::ORD_AB;
    logic               signed_value = 1'b0;
    logic [7:0]         rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               out_kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [7:0]         attempts_used;

    // Bookkeeping
    result_word_t pending_results[$];
    result_word_t head_w;
    int           err_cnt = 0;
    int           cycle_cnt = 0;
    int           words_sent = 0;
    int           stall_left = 0;
    bit           steady = 1'b0;

    // Model: configuration
    logic        cfg_en;
    logic [7:0]  cfg_max;
    logic [15:0] cfg_timeout;

    // Model: transaction state
    bit          awaiting;
    logic [7:0]  req_frame [0:7];
    logic [7:0]  fail_cnt;
    logic [15:0] tick_cnt;
    logic [6:0]  rx_pos;
    logic [6:0]  reply_len;
    logic [15:0] run_crc;
    logic [7:0]  rep_slave;
    logic [7:0]  rep_bcount;
    logic [31:0] cap_bytes;
    logic [15:0] tail_crc;
    logic [2:0]  ord_held;
    logic        sign_held;

    modbus_rtu_read_transaction_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .slave_addr    (slave_addr),
        .func_code     (func_code),
        .reg_addr      (reg_addr),
        .reg_count     (reg_count),
        .value_order   (value_order),
        .signed_value  (signed_value),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (out_kind),
        .tx_byte       (tx_byte),
        .last          (last),
        .status        (status),
        .value         (value),
        .attempts_used (attempts_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model of the master
    // ------------------------------------------------------------------

    // Reflected CRC-16, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    function automatic void push_result(input logic kind, input logic [7:0] tx,
                                        input logic lst, input logic [1:0] st,
                                        input logic [31:0] val, input logic [7:0] att);
        result_word_t r;
        r.kind = kind;
        r.tx   = tx;
        r.last = lst;
        r.st   = st;
        r.val  = val;
        r.att  = att;
        pending_results.push_back(r);
    endfunction

    // Eight request bytes, then a fresh attempt
    function automatic void emit_request();
        for (int i = 0; i < 8; i++)
            push_result(mbrt_pkg::KIND_TX, req_frame[i], i == 7, mbrt_pkg::ST_OK,
                        32'h0, 8'h0);
        tick_cnt   = '0;
        rx_pos     = '0;
        run_crc    = 16'hFFFF;
        rep_slave  = '0;
        rep_bcount = '0;
        cap_bytes  = '0;
        tail_crc   = '0;
        awaiting   = 1'b1;
    endfunction

    function automatic void finish_txn(input logic [1:0] st, input logic [31:0] val,
                                       input logic [7:0] att);
        push_result(mbrt_pkg::KIND_DONE, 8'h0, 1'b1, st, val, att);
        awaiting = 1'b0;
    endfunction

    function automatic void attempt_lost();
        fail_cnt = fail_cnt + 8'd1;
        if (fail_cnt < cfg_max)
            emit_request();
        else
            finish_txn(mbrt_pkg::ST_FAILED, 32'h0, fail_cnt);
    endfunction

    // Register value from the captured payload, by byte count and held order
    function automatic logic [31:0] decoded_value();
        logic [7:0]  b0, b1, b2, b3;
        logic [31:0] raw;
        {b0, b1, b2, b3} = cap_bytes;
        raw = '0;
        if (rep_bcount == 8'd2)
        begin
            raw = (ord_held == mbrt_pkg::ORD_BA) ? {16'h0, b1, b0} : {16'h0, b0, b1};
            if (sign_held && raw[15])
                raw[31:16] = 16'hFFFF;
        end
        else if (rep_bcount == 8'd4)
        begin
            case (ord_held)
                mbrt_pkg::ORD_CDBA: raw = {b2, b3, b0, b1};
                mbrt_pkg::ORD_BADC: raw = {b1, b0, b3, b2};
                mbrt_pkg::ORD_DCBA: raw = {b3, b2, b1, b0};
                default:            raw = {b0, b1, b2, b3};
            endcase
        end
        return raw;
    endfunction

    // Advance the master by one accepted input word, queueing what it emits
    function automatic void advance_master(input in_word_t w);
        int unsigned len;
        int          idx;
        logic [15:0] c;
        case (w.kind)
            mbrt_pkg::REQ_START:
            begin
                len = 5 + 2 * int'(w.count);
                awaiting = 1'b0;
                fail_cnt = '0;
                if (!cfg_en)
                    finish_txn(mbrt_pkg::ST_DISABLED, 32'h0, 8'h0);
                else if (len > mbrt_pkg::MAX_FRAME)
                    finish_txn(mbrt_pkg::ST_TOO_LONG, 32'h0, 8'h0);
                else if (cfg_max == 8'd0)
                    finish_txn(mbrt_pkg::ST_FAILED, 32'h0, 8'h0);
                else
                begin
                    req_frame[0] = w.slave;
                    req_frame[1] = w.func;
                    req_frame[2] = w.addr[15:8];
                    req_frame[3] = w.addr[7:0];
                    req_frame[4] = w.count[15:8];
                    req_frame[5] = w.count[7:0];
                    c = 16'hFFFF;
                    for (int i = 0; i < 6; i++)
                        c = crc16_step(c, req_frame[i]);
                    req_frame[6] = c[7:0];
                    req_frame[7] = c[15:8];
                    reply_len = len[6:0];
                    ord_held  = w.order;
                    sign_held = w.sgn;
                    emit_request();
                end
            end
            mbrt_pkg::REQ_BYTE:
            begin
                if (awaiting)
                begin
                    idx = int'(rx_pos);
                    if (idx == 0)
                        rep_slave = w.rxb;
                    if (idx == 2)
                        rep_bcount = w.rxb;
                    if (idx >= 3 && idx <= 6)
                        cap_bytes = cap_bytes | ({24'h0, w.rxb} << (8 * (6 - idx)));
                    if (idx + 2 < int'(reply_len))
                        run_crc = crc16_step(run_crc, w.rxb);
                    else if (idx + 2 == int'(reply_len))
                        tail_crc = {8'h00, w.rxb};
                    else if (idx + 1 == int'(reply_len))
                        tail_crc = tail_crc | {w.rxb, 8'h00};
                    rx_pos = rx_pos + 7'd1;
                    if (rx_pos >= reply_len)
                    begin
                        if (rep_slave == req_frame[0] && tail_crc == run_crc)
                            finish_txn(mbrt_pkg::ST_OK, decoded_value(), fail_cnt);
                        else
                            attempt_lost();
                    end
                end
            end
            mbrt_pkg::REQ_TICK:
            begin
                if (awaiting)
                begin
                    if (tick_cnt != 16'hFFFF)
                        tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= cfg_timeout)
                        attempt_lost();
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int send_gap();
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    // Word with every field random, of the given type
    function automatic in_word_t make_word(input logic [1:0] kind);
        in_word_t w;
        w.kind  = kind;
        w.slave = 8'($urandom_range(0, 255));
        w.func  = 8'($urandom_range(0, 255));
        w.addr  = 16'($urandom_range(0, 65535));
        w.count = 16'($urandom_range(0, 65535));
        w.order = 3'($urandom_range(0, 5));
        w.sgn   = 1'($urandom_range(0, 1));
        w.rxb   = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Drive one input word and wait until it is taken
    task automatic send_word(input in_word_t w);
        int gap;
        gap = send_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type     <= w.kind;
        slave_addr   <= w.slave;
        func_code    <= w.func;
        reg_addr     <= w.addr;
        reg_count    <= w.count;
        value_order  <= w.order;
        signed_value <= w.sgn;
        rx_byte      <= w.rxb;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        advance_master(w);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(make_word(mbrt_pkg::REQ_TICK));
    endtask

    task automatic send_start(input logic [15:0] count, input logic [2:0] order,
                              input logic sgn);
        in_word_t w;
        w = make_word(mbrt_pkg::REQ_START);
        w.count = count;
        w.order = order;
        w.sgn   = sgn;
        send_word(w);
    endtask

    // Reply to the pending request; bcount >= 0 sets the byte-count field, bcount < 0 picks it at random,
    // set_mask is ORed into every payload byte
    task automatic send_reply(input reply_fault_t fault, input int bcount,
                              input logic [7:0] set_mask);
        logic [7:0]  fb [0:63];
        logic [15:0] c;
        in_word_t    w;
        int          len;
        int          r;
        int          k;
        len = int'(reply_len);
        fb[0] = req_frame[0];
        if (fault == REPLY_BAD_SLAVE)
            fb[0] = req_frame[0] ^ 8'($urandom_range(1, 255));
        fb[1] = req_frame[1];
        r = $urandom_range(0, 99);
        if (bcount >= 0)
            fb[2] = bcount[7:0];
        else if (r < 80)
            fb[2] = 8'(len - 5);
        else if (r < 90)
            fb[2] = ($urandom_range(0, 1) == 0) ? 8'd2 : 8'd4;
        else
            fb[2] = 8'($urandom_range(0, 255));
        for (int i = 3; i < len - 2; i++)
            fb[i] = 8'($urandom_range(0, 255)) | set_mask;
        c = 16'hFFFF;
        for (int i = 0; i < len - 2; i++)
            c = crc16_step(c, fb[i]);
        fb[len - 2] = c[7:0];
        fb[len - 1] = c[15:8];
        if (fault == REPLY_BAD_CRC)
        begin
            k = len - 2 + $urandom_range(0, 1);
            fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < len; i++)
        begin
            // ticks between bytes, never enough to time out
            if ($urandom_range(0, 4) == 0 && int'(tick_cnt) + 1 < int'(cfg_timeout))
                send_tick();
            w = make_word(mbrt_pkg::REQ_BYTE);
            w.rxb = fb[i];
            send_word(w);
        end
    endtask

    // Drop any open transaction, drain the results, let the block settle
    task automatic quiesce();
        if (awaiting)
            send_start(16'd30, mbrt_pkg::ORD_AB, 1'b0);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mbrt_pkg::CFG_ENABLE:  cfg_en      = data[0];
            mbrt_pkg::CFG_MAX_ATT: cfg_max     = data[7:0];
            mbrt_pkg::CFG_TIMEOUT: cfg_timeout = data[15:0];
            default: ;
        endcase
    endtask

    // One random transaction: start, then replies, faults, timeouts or abandonment
    task automatic run_transaction();
        int  r;
        int  tries;
        int  k;
        bit  abandon;
        logic [7:0] lost_before;
        logic [15:0] count;
        steady = ($urandom_range(0, 4) == 0);
        // stray word, ignored unless a transaction was left open
        if ($urandom_range(0, 9) == 0)
            send_word(make_word($urandom_range(0, 1) ? mbrt_pkg::REQ_BYTE
                                                     : mbrt_pkg::REQ_TICK));
        r = $urandom_range(0, 9);
        if (r < 7)
            count = 16'($urandom_range(0, 4));
        else if (r < 8)
            count = 16'($urandom_range(5, 29));
        else
            count = 16'($urandom_range(30, 65535));
        send_start(count, 3'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
        tries = 0;
        abandon = 1'b0;
        while (awaiting && tries < 6 && !abandon)
        begin
            tries++;
            r = $urandom_range(0, 99);
            if (r < 60)
                send_reply(REPLY_GOOD, -1, 8'h00);
            else if (r < 72)
                send_reply(REPLY_BAD_SLAVE, -1, 8'h00);
            else if (r < 84 || (r < 94 && cfg_timeout > 16'd16))
                send_reply(REPLY_BAD_CRC, -1, 8'h00);
            else
            begin
                // part of a reply
                k = $urandom_range(0, int'(reply_len) - 1);
                for (int i = 0; i < k; i++)
                    send_word(make_word(mbrt_pkg::REQ_BYTE));
                if (r < 94)
                begin
                    // then silence until the attempt times out
                    lost_before = fail_cnt;
                    while (awaiting && fail_cnt == lost_before)
                        send_tick();
                end
                else
                    abandon = 1'b1;
            end
        end
    endtask

    task automatic run_random(input int budget);
        int first;
        first = words_sent;
        while (words_sent - first < budget)
            run_transaction();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes and ticks while idle are ignored; a start while disabled finishes at once
    task automatic test_idle_and_disabled();
        in_word_t w;
        send_word(make_word(mbrt_pkg::REQ_BYTE));
        send_tick();
        w = make_word(mbrt_pkg::REQ_START);
        w.slave = 8'hFF;
        w.func  = 8'hFF;
        w.addr  = 16'hFFFF;
        w.count = 16'hFFFF;
        w.order = mbrt_pkg::ORD_DCBA;
        w.sgn   = 1'b1;
        send_word(w);
    endtask

    // Reply-too-long and zero-attempt starts send nothing
    task automatic test_frame_limits();
        quiesce();
        cfg_write(mbrt_pkg::CFG_ENABLE, 16'd1);
        send_start(16'd30, mbrt_pkg::ORD_AB, 1'b0);
        send_start(16'hFFFF, mbrt_pkg::ORD_BA, 1'b1);
        quiesce();
        cfg_write(mbrt_pkg::CFG_MAX_ATT, 16'd0);
        send_start(16'd1, mbrt_pkg::ORD_AB, 1'b0);
    endtask

    // 32-bit read in reversed order, 16-bit signed read with swapped bytes
    task automatic test_decode_orders();
        quiesce();
        cfg_write(mbrt_pkg::CFG_MAX_ATT, 16'd3);
        cfg_write(mbrt_pkg::CFG_TIMEOUT, 16'd1000);
        send_start(16'd2, mbrt_pkg::ORD_DCBA, 1'b0);
        send_reply(REPLY_GOOD, 4, 8'h00);
        send_start(16'd1, mbrt_pkg::ORD_BA, 1'b1);
        send_reply(REPLY_GOOD, 2, 8'h80);
    endtask

    // Timeout retries, restart while waiting, failure after the last attempt
    task automatic test_retry_timeout();
        quiesce();
        cfg_write(mbrt_pkg::CFG_MAX_ATT, 16'd2);
        cfg_write(mbrt_pkg::CFG_TIMEOUT, 16'd1);
        send_start(16'd0, mbrt_pkg::ORD_AB, 1'b0);
        send_tick();
        send_start(16'd1, mbrt_pkg::ORD_AB, 1'b0);
        send_tick();
        send_tick();
    endtask

    task automatic test_random_default();
        quiesce();
        cfg_write(mbrt_pkg::CFG_MAX_ATT, 16'd3);
        cfg_write(mbrt_pkg::CFG_TIMEOUT, 16'd4);
        run_random(15);
    endtask

    // Most retries, longest timeout
    task automatic test_random_patient();
        quiesce();
        cfg_write(mbrt_pkg::CFG_MAX_ATT, 16'd255);
        cfg_write(mbrt_pkg::CFG_TIMEOUT, 16'hFFFF);
        run_random(15);
    endtask

    // Single attempt, shortest timeout
    task automatic test_random_strict();
        quiesce();
        cfg_write(mbrt_pkg::CFG_MAX_ATT, 16'd1);
        cfg_write(mbrt_pkg::CFG_TIMEOUT, 16'd1);
        run_random(15);
    endtask

    task automatic test_disabled_traffic();
        quiesce();
        cfg_write(mbrt_pkg::CFG_ENABLE, 16'd0);
        run_random(5);
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: kind %0d tx 0x%0h status %0d",
                       out_kind, tx_byte, status);
                err_cnt++;
            end
            else
            begin
                head_w = pending_results.pop_front();
                check_field("out_kind", 32'(head_w.kind), 32'(out_kind));
                check_field("tx_byte", 32'(head_w.tx), 32'(tx_byte));
                check_field("last", 32'(head_w.last), 32'(last));
                check_field("status", 32'(head_w.st), 32'(status));
                check_field("value", head_w.val, value);
                check_field("attempts_used", 32'(head_w.att), 32'(attempts_used));
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (steady || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready  <= 1'b0;
            stall_left <= idle_len() - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("modbus_rtu_read_transaction_top_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_en      = 1'b0;
        cfg_max     = 8'd3;
        cfg_timeout = 16'd1000;
        awaiting    = 1'b0;
        fail_cnt    = '0;
        tick_cnt    = '0;
        rx_pos      = '0;
        reply_len   = '0;
        run_crc     = 16'hFFFF;
        rep_slave   = '0;
        rep_bcount  = '0;
        cap_bytes   = '0;
        tail_crc    = '0;
        ord_held    = '0;
        sign_held   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_disabled();
        test_frame_limits();
        test_decode_orders();
        test_retry_timeout();
        test_random_default();
        test_random_patient();
        test_random_strict();
        test_disabled_traffic();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("modbus_rtu_read_transaction_top_tb: done, clean");
        else
            $display("modbus_rtu_read_transaction_top_tb: done, errors");
        $finish;
    end

endmodule
